[hdl/rmst_pkg.sv]
package rmst_pkg;

    localparam int LEAVES  = 1024;
    localparam int LEAF_W  = $clog2(LEAVES);
    localparam int NODE_W  = LEAF_W + 1;
    localparam int BOUND_W = NODE_W + 1;
    localparam int VAL_W   = 64;
    localparam int POS_W   = 10;
    localparam int RANGE_W = 11;
    localparam int IN_DATA_W = 96;

    localparam logic [VAL_W-1:0] CAP_VALUE = VAL_W'(64'd2147483647);

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_U_READ,
        ST_U_WAIT,
        ST_Q_LO,
        ST_Q_HI,
        ST_Q_DONE
    } walk_state_t;

    typedef struct packed {
        logic               op;
        logic [POS_W-1:0]   position;
        logic [VAL_W-1:0]   new_value;
        logic [RANGE_W-1:0] range_start;
        logic [RANGE_W-1:0] range_end;
    } in_item_t;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } mem_req_t;

    function automatic logic [VAL_W-1:0] smin(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
        return ($signed(a) < $signed(b)) ? a : b;
    endfunction

    // saturate a range bound to the leaf count and move it to its leaf node
    function automatic logic [BOUND_W-1:0] bound_node(input logic [RANGE_W-1:0] b);
        logic [BOUND_W-1:0] sat;
        sat = (BOUND_W'(b) > BOUND_W'(LEAVES)) ? BOUND_W'(LEAVES) : BOUND_W'(b);
        return sat + BOUND_W'(LEAVES);
    endfunction

endpackage

[hdl/rmst_mem.sv]
module rmst_mem
    import rmst_pkg::*;
(
    input  logic             clk,
    input  mem_req_t         req,
    output logic [VAL_W-1:0] rd_data
);

    logic [VAL_W-1:0] nodes [2*LEAVES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            nodes[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data <= nodes[req.raddr];
        end
    end

endmodule

[hdl/rmst_walk.sv]
module rmst_walk
    import rmst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         item,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             res_valid,
    output logic [VAL_W-1:0] res_data,
    input  logic             res_ready,
    output mem_req_t         mem_req,
    input  logic [VAL_W-1:0] rd_data
);

    walk_state_t        state_reg, state_next;
    logic [NODE_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [VAL_W-1:0]   cur_reg, cur_next;
    logic [BOUND_W-1:0] lo_reg, lo_next;
    logic [BOUND_W-1:0] hi_reg, hi_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               accept;
    logic [VAL_W-1:0]   parent_val;
    logic [BOUND_W-1:0] hi_dec;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign res_valid  = (state_reg == ST_Q_DONE);
    assign res_data   = acc_reg;
    assign parent_val = smin(cur_reg, rd_data);
    assign hi_dec     = hi_reg - BOUND_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.op == OP_QUERY) ? ST_Q_LO : ST_U_READ;
                end
            end
            ST_U_READ:
            begin
                state_next = (node_reg == NODE_W'(1)) ? ST_IDLE : ST_U_WAIT;
            end
            ST_U_WAIT:
            begin
                state_next = ST_U_READ;
            end
            ST_Q_LO:
            begin
                state_next = (lo_reg >= hi_reg) ? ST_Q_DONE : ST_Q_HI;
            end
            ST_Q_HI:
            begin
                state_next = ST_Q_LO;
            end
            ST_Q_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        node_next    = node_reg;
        cur_next     = cur_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        acc_next     = acc_reg;
        mem_req      = '0;

        // fold in the node read in the previous cycle
        if (rd_pend_reg && (state_reg == ST_Q_LO || state_reg == ST_Q_HI))
        begin
            acc_next = smin(acc_reg, rd_data);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                mem_req.wdata = CAP_VALUE;
                clr_cnt_next  = clr_cnt_reg + NODE_W'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op == OP_UPDATE)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = {1'b1, item.position};
                        mem_req.wdata = item.new_value;
                        node_next     = {1'b1, item.position};
                        cur_next      = item.new_value;
                    end
                    else
                    begin
                        lo_next  = bound_node(item.range_start);
                        hi_next  = bound_node(item.range_end);
                        acc_next = CAP_VALUE;
                    end
                end
            end
            ST_U_READ:
            begin
                if (node_reg != NODE_W'(1))
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = node_reg ^ NODE_W'(1);
                end
            end
            ST_U_WAIT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = node_reg >> 1;
                mem_req.wdata = parent_val;
                cur_next      = parent_val;
                node_next     = node_reg >> 1;
            end
            ST_Q_LO:
            begin
                if (lo_reg < hi_reg && lo_reg[0])
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = lo_reg[NODE_W-1:0];
                    lo_next       = lo_reg + BOUND_W'(1);
                end
            end
            ST_Q_HI:
            begin
                if (hi_reg[0])
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = hi_dec[NODE_W-1:0];
                end
                // an odd bound drops its low bit either way
                hi_next = hi_reg >> 1;
                lo_next = lo_reg >> 1;
            end
            ST_Q_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        rd_pend_next = mem_req.re;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cur_reg  <= cur_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        acc_reg  <= acc_next;
    end

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("tree write and read hit the same node");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("item taken during clearing pass");

    a_result_complete: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !rd_pend_reg)
        else $error("result shown with a node read still in flight");

    a_update_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_U_WAIT) |=> (state_reg == ST_U_READ && node_reg != '0))
        else $error("update walk left the tree");

endmodule

[hdl/range_min_segment_tree.sv]
// Range-minimum segment tree over 1024 signed 64-bit leaves, held bottom-up in
// one 2048 x 64 synchronous memory. After reset the block runs a clearing pass
// that loads every node with 2147483647; s_tready stays low until it ends.
// An update (tuser = 0) writes the leaf and walks to the root: one sibling read
// and one parent write per level, and no new item is taken until the walk ends.
// A query (tuser = 1) returns the minimum over the leaves from range_start up
// to but not including range_end, capped at 2147483647; it climbs the tree
// with a low-bound step and a high-bound step per level. The walks are paced
// by the single read port of the tree memory, whose read data is registered.
// Updates give no output transfer. A finished result sits in an output
// register, so the next item is taken while it waits.
module range_min_segment_tree
    import rmst_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,  // position, new_value, range_start, range_end
    input  logic                 s_tuser,  // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VAL_W-1:0]     m_tdata   // min_value
);

    in_item_t         item;
    mem_req_t         mem_req;
    logic [VAL_W-1:0] rd_data;
    logic             res_valid;
    logic             res_ready;
    logic [VAL_W-1:0] res_data;
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] out_data_reg, out_data_next;

    assign item.op          = s_tuser;
    assign item.position    = s_tdata[9:0];
    assign item.new_value   = s_tdata[73:10];
    assign item.range_start = s_tdata[84:74];
    assign item.range_end   = s_tdata[95:85];

    rmst_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    rmst_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // load the output register when it is empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_data_next = res_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
